/* design/bba_pkg.sv */
// ---------------------------------------------------------------------------
// bba_pkg
// shared types, codes and defaults of the bitmap block allocator
// ---------------------------------------------------------------------------
package bba_pkg;

    // fixed field widths
    localparam int CFG_W   = 12;
    localparam int BLK_W   = 11;
    localparam int ST_W    = 2;
    localparam int CIDX_W  = 2;

    // parameter defaults
    localparam int DISK_COUNT_DEF = 2;
    localparam int MAX_BLOCKS_DEF = 2048;
    localparam int WORD_BITS_DEF  = 32;

    // register reset values
    localparam logic [CFG_W-1:0] TOTAL_RST = 12'd2048;
    localparam logic [CFG_W-1:0] RESV_RST  = 12'd1;

    typedef enum logic [ST_W-1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_INVALID     = 2'd3
    } t_status;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req_type;

    typedef enum logic [CIDX_W-1:0] {
        CFG_TOTAL0 = 2'd0,
        CFG_TOTAL1 = 2'd1,
        CFG_RESV0  = 2'd2,
        CFG_RESV1  = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

/* design/bba_ifs.sv */
// ---------------------------------------------------------------------------
// bba request / response channels
// valid-ready channels carrying allocator requests and their results
// ---------------------------------------------------------------------------
interface bba_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic                       disk_select;
    logic [bba_pkg::BLK_W-1:0]  block_number;

    modport source (output valid, output req_type, output disk_select,
                    output block_number, input ready);
    modport sink   (input valid, input req_type, input disk_select,
                    input block_number, output ready);
endinterface

interface bba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [bba_pkg::BLK_W-1:0]  allocated_block;
    logic [bba_pkg::ST_W-1:0]   status;

    modport source (output valid, output allocated_block, output status,
                    input ready);
    modport sink   (input valid, input allocated_block, input status,
                    output ready);
endinterface

/* design/bba_bitmap_mem.sv */
// ---------------------------------------------------------------------------
// bba_bitmap_mem
// bitmap word store, one read and one write port, registered read,
// per-word valid bits so that unwritten words read as all free
// ---------------------------------------------------------------------------
module bba_bitmap_mem #(
    parameter int DEPTH     = 128,
    parameter int WORD_BITS = 32,
    parameter int AW        = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data
);

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]     r_vld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // never-written word means every block in it is free
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* design/bba_word_find.sv */
// ---------------------------------------------------------------------------
// bba_word_find
// first free bit of one bitmap word inside a window [lo, hi)
// ---------------------------------------------------------------------------
module bba_word_find #(
    parameter int WORD_BITS = 32,
    parameter int SW        = 5,
    parameter int CW        = 6
) (
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [CW-1:0]        i_lo,
    input  logic [CW-1:0]        i_hi,
    output logic                 o_found,
    output logic [SW-1:0]        o_idx,
    output logic [WORD_BITS-1:0] o_onehot
);

    logic [WORD_BITS-1:0] lo_m;
    logic [WORD_BITS-1:0] hi_m;
    logic [WORD_BITS-1:0] cand;

    always_comb begin
        lo_m = (32'(i_lo) >= WORD_BITS) ? '0 : ({WORD_BITS{1'b1}} << i_lo);
        hi_m = (32'(i_hi) >= WORD_BITS) ? '1 : ~({WORD_BITS{1'b1}} << i_hi);
        cand = ~i_word & lo_m & hi_m;
    end

    // lowest set candidate wins
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                o_found = 1'b1;
                o_idx   = SW'(i);
            end
        end
    end

    assign o_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << o_idx;

endmodule

/* design/bitmap_block_allocator_unit.sv */
// ---------------------------------------------------------------------------
// bitmap_block_allocator_unit
// first-fit block allocator over one used/free bitmap per disk
// ---------------------------------------------------------------------------
// usage:
//   requests come in on i_req (valid/ready): allocate or free, a disk and,
//   for free, a block number. each request gives exactly one response on
//   o_rsp: the granted block (0 when none or on free) and a status code.
//   the bitmap lives in one synchronous ram, WORD_BITS blocks per word,
//   and is walked one word per cycle starting at word 0 of the disk.
//   allocate: the walk stops at the first word holding a free block in
//   [reserved, total), or at the word holding the last block of the disk.
//   free: the walk stops at the word holding the block.
//   the walk covers at most MAX_BLOCKS/WORD_BITS words (64 at defaults);
//   requests rejected by the range checks end on the first word. ready
//   returns in the same cycle that the response turns valid. the ram
//   read port, one word per cycle, sets the pace. one request in flight.
//   a finished response sits in an output register; the unit takes the next
//   request while it waits. if the receiver stalls with the output still
//   full, the next response is held in the done state until it drains.
//   reset: synchronous, active low; register defaults apply and every block
//   reads as free at once (per-word valid bits, no clearing pass).
//   configuration is to be written on i_cfg_* only while the unit is idle;
//   the unit itself does not enforce this.
// ---------------------------------------------------------------------------
module bitmap_block_allocator_unit #(
    parameter int DISK_COUNT = bba_pkg::DISK_COUNT_DEF,
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BITS  = bba_pkg::WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bba_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [bba_pkg::CFG_W-1:0]  i_cfg_data,
    bba_req_if.sink                    i_req,
    bba_rsp_if.source                  o_rsp
);

    import bba_pkg::*;

    localparam int WPD   = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH = DISK_COUNT * WPD;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(WORD_BITS);
    localparam int CW    = $clog2(WORD_BITS + 1);
    // block arithmetic width: holds config values and base + one word
    localparam int NB    = $clog2(MAX_BLOCKS + 2 * WORD_BITS) + 1;
    localparam int NW    = (NB > CFG_W + 1) ? NB : CFG_W + 1;

    // configuration registers
    logic [CFG_W-1:0] r_total0, r_total1, r_resv0, r_resv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total0 <= TOTAL_RST;
            r_total1 <= TOTAL_RST;
            r_resv0  <= RESV_RST;
            r_resv1  <= RESV_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TOTAL0: r_total0 <= i_cfg_data;
                CFG_TOTAL1: r_total1 <= i_cfg_data;
                CFG_RESV0:  r_resv0  <= i_cfg_data;
                CFG_RESV1:  r_resv1  <= i_cfg_data;
            endcase
        end
    end

    // request state
    t_state          r_state, n_state;
    logic            r_req_free;
    logic [NW-1:0]   r_blk;
    logic [NW-1:0]   r_lim;
    logic [NW-1:0]   r_flr;
    logic            r_pre;        // result known at accept time
    t_status         r_pre_st;
    logic [NW-1:0]   r_base;       // block number of bit 0 of the word in flight
    logic [AW-1:0]   r_addr;       // ram address of the word in flight
    logic [BLK_W-1:0] r_res_blk;
    t_status         r_res_st;
    logic            r_out_valid;
    logic [BLK_W-1:0] r_out_blk;
    t_status         r_out_st;

    // accept side decode
    logic            accept;
    logic [CFG_W-1:0] sel_total, sel_resv;
    logic [NW-1:0]   a_lim, a_flr, a_blk;
    logic            a_pre;
    t_status         a_pre_st;
    logic [AW-1:0]   a_addr;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        sel_total = i_req.disk_select ? r_total1 : r_total0;
        sel_resv  = i_req.disk_select ? r_resv1  : r_resv0;
        a_lim     = (NW'(sel_total) > NW'(MAX_BLOCKS)) ? NW'(MAX_BLOCKS) : NW'(sel_total);
        // block 0 doubles as the failure code, so the floor is at least 1
        a_flr     = (sel_resv == '0) ? NW'(1) : NW'(sel_resv);
        a_blk     = NW'(i_req.block_number);
        a_addr    = i_req.disk_select ? AW'(WPD) : '0;
        a_pre     = 1'b0;
        a_pre_st  = ST_OK;
        if (32'(i_req.disk_select) >= DISK_COUNT) begin
            a_pre    = 1'b1;
            a_pre_st = ST_INVALID;
        end else if (t_req_type'(i_req.req_type) == REQ_ALLOC) begin
            if (a_flr >= a_lim) begin
                a_pre    = 1'b1;
                a_pre_st = ST_FULL;
            end
        end else if (a_blk >= a_lim || a_blk < a_flr) begin
            a_pre    = 1'b1;
            a_pre_st = ST_INVALID;
        end
    end

    // word window and search
    logic [WORD_BITS-1:0] rd_word;
    logic [NW:0]          lo_d, hi_d, pos_d;
    logic [CW-1:0]        win_lo, win_hi;
    logic                 fd_found;
    logic [SW-1:0]        fd_idx;
    logic [WORD_BITS-1:0] fd_onehot;
    logic [SW-1:0]        fr_pos;
    logic [WORD_BITS-1:0] fr_onehot;
    logic                 fr_here;
    logic                 al_last;
    logic [NW-1:0]        base_next;

    always_comb begin
        base_next = r_base + NW'(WORD_BITS);
        lo_d      = {1'b0, r_flr} - {1'b0, r_base};
        hi_d      = {1'b0, r_lim} - {1'b0, r_base};
        pos_d     = {1'b0, r_blk} - {1'b0, r_base};
        // clamp the offsets into 0..WORD_BITS
        if (lo_d[NW]) begin
            win_lo = '0;
        end else if (lo_d > (NW+1)'(WORD_BITS)) begin
            win_lo = CW'(WORD_BITS);
        end else begin
            win_lo = lo_d[CW-1:0];
        end
        if (hi_d[NW]) begin
            win_hi = '0;
        end else if (hi_d > (NW+1)'(WORD_BITS)) begin
            win_hi = CW'(WORD_BITS);
        end else begin
            win_hi = hi_d[CW-1:0];
        end
        fr_pos    = pos_d[SW-1:0];
        fr_onehot = {{(WORD_BITS-1){1'b0}}, 1'b1} << fr_pos;
        fr_here   = (r_blk < base_next);
        al_last   = (base_next >= r_lim);
    end

    bba_word_find #(
        .WORD_BITS (WORD_BITS),
        .SW        (SW),
        .CW        (CW)
    ) u_find (
        .i_word   (rd_word),
        .i_lo     (win_lo),
        .i_hi     (win_hi),
        .o_found  (fd_found),
        .o_idx    (fd_idx),
        .o_onehot (fd_onehot)
    );

    // scan outcome for the word in flight
    logic                 sc_done;
    logic                 sc_wr;
    logic [WORD_BITS-1:0] sc_wdata;
    logic [BLK_W-1:0]     sc_blk;
    t_status              sc_st;

    always_comb begin
        sc_done  = 1'b0;
        sc_wr    = 1'b0;
        sc_wdata = rd_word;
        sc_blk   = '0;
        sc_st    = ST_OK;
        priority if (r_pre) begin
            sc_done = 1'b1;
            sc_st   = r_pre_st;
        end else if (!r_req_free) begin
            if (fd_found) begin
                sc_done  = 1'b1;
                sc_wr    = 1'b1;
                sc_wdata = rd_word | fd_onehot;
                sc_blk   = BLK_W'(r_base + NW'(fd_idx));
                sc_st    = ST_OK;
            end else if (al_last) begin
                sc_done = 1'b1;
                sc_st   = ST_FULL;
            end
        end else if (fr_here) begin
            sc_done = 1'b1;
            if ((rd_word & fr_onehot) != '0) begin
                sc_wr    = 1'b1;
                sc_wdata = rd_word & ~fr_onehot;
                sc_st    = ST_OK;
            end else begin
                sc_st = ST_DOUBLE_FREE;
            end
        end
    end

    // next state
    logic out_free;
    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept)   n_state = S_SCAN;
            S_SCAN: if (sc_done)  n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default:              n_state = S_IDLE;
        endcase
    end

    // state outputs: ram control
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_addr + AW'(1);
        wr_en   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                rd_en   = accept;
                rd_addr = a_addr;
            end
            S_SCAN: begin
                rd_en = !sc_done;
                wr_en = sc_wr;
            end
            S_DONE: begin
                rd_en = 1'b0;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // a write lands at the end of the scan, well before the next request
    // can issue its first read, so no forwarding is needed
    bba_bitmap_mem #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .AW        (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_word),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (sc_wdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_free <= (t_req_type'(i_req.req_type) == REQ_FREE);
            r_blk      <= a_blk;
            r_lim      <= a_lim;
            r_flr      <= a_flr;
            r_pre      <= a_pre;
            r_pre_st   <= a_pre_st;
            r_base     <= '0;
        end else if (r_state == S_SCAN && !sc_done) begin
            r_base <= base_next;
        end
        if (rd_en) begin
            r_addr <= rd_addr;
        end
        if (r_state == S_SCAN && sc_done) begin
            r_res_blk <= sc_blk;
            r_res_st  <= sc_st;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_blk <= r_res_blk;
            r_out_st  <= r_res_st;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.allocated_block = r_out_blk;
    assign o_rsp.status          = r_out_st;

endmodule

/* verif/tb.sv */
// ---------------------------------------------------------------------------
// tb: bitmap_block_allocator_unit testbench
// drives allocate and free requests with random gaps on both channels, keeps
// its own copy of both disk bitmaps and the four registers, and checks every
// response against the predicted grant and status. directed cases first,
// then random phases under changing block and reserved counts
// ---------------------------------------------------------------------------
module tb;
    import bba_pkg::*;

    localparam int DISKS         = DISK_COUNT_DEF;
    localparam int MAX_BLOCKS    = MAX_BLOCKS_DEF;
    localparam int IDLE_LIMIT    = 2000;   // cycles with no handshake at all
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 210;

    // one expected response
    typedef struct packed {
        logic [BLK_W-1:0] blk;
        t_status          st;
    } t_grant_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    bitmap_block_allocator_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // shadow of the allocator: registers and both used/free bitmaps
    logic [CFG_W-1:0]      total_cfg [DISKS] = '{TOTAL_RST, TOTAL_RST};
    logic [CFG_W-1:0]      resv_cfg  [DISKS] = '{RESV_RST, RESV_RST};
    bit [MAX_BLOCKS-1:0]   used_map  [DISKS];

    t_grant_result pending_grants [$];
    int  fail_count  = 0;
    int  idle_cycles = 0;
    bit  no_idle     = 1'b0;   // phases with back-to-back traffic
    int  stall_left  = 0;
    t_grant_result want;

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------

    // block count, clipped to the bitmap size
    function automatic int disk_limit(input logic disk);
        int t;
        t = total_cfg[disk];
        return (t > MAX_BLOCKS) ? MAX_BLOCKS : t;
    endfunction

    // reserved count, zero acts as one since block 0 is the failure code
    function automatic int disk_floor(input logic disk);
        return (resv_cfg[disk] == '0) ? 1 : int'(resv_cfg[disk]);
    endfunction

    // first-fit grant or free, updates the shadow bitmap
    function automatic t_grant_result grant_or_release(input t_req_type req,
                                                       input logic disk,
                                                       input logic [BLK_W-1:0] blk);
        t_grant_result res;
        int lim;
        int flo;
        lim = disk_limit(disk);
        flo = disk_floor(disk);
        res.blk = '0;
        if (req == REQ_ALLOC) begin
            res.st = ST_FULL;
            for (int b = flo; b < lim; b++) begin
                if (!used_map[disk][b]) begin
                    used_map[disk][b] = 1'b1;
                    res.blk = BLK_W'(b);
                    res.st  = ST_OK;
                    break;
                end
            end
        end else if (int'(blk) >= lim || int'(blk) < flo) begin
            res.st = ST_INVALID;
        end else if (!used_map[disk][blk]) begin
            res.st = ST_DOUBLE_FREE;
        end else begin
            used_map[disk][blk] = 1'b0;
            res.st = ST_OK;
        end
        return res;
    endfunction

    // some used block in range, searched from a random start; if none is
    // used the start block itself comes back, which makes a double free
    function automatic logic [BLK_W-1:0] pick_used_block(input logic disk);
        int lim;
        int flo;
        int span;
        int start;
        int b;
        lim = disk_limit(disk);
        flo = disk_floor(disk);
        if (flo >= lim)
            return BLK_W'($urandom_range(0, MAX_BLOCKS - 1));
        span  = lim - flo;
        start = $urandom_range(flo, lim - 1);
        for (int i = 0; i < span; i++) begin
            b = flo + (start - flo + i) % span;
            if (used_map[disk][b])
                return BLK_W'(b);
        end
        return BLK_W'(start);
    endfunction

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CFG_W-1:0] pick_total();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return CFG_W'($urandom_range(2, 160));
        else if (r < 75)
            return CFG_W'(MAX_BLOCKS);
        else if (r < 85)
            return CFG_W'($urandom_range(MAX_BLOCKS + 1, 4095));
        else if (r < 90)
            return CFG_W'($urandom_range(0, 1));
        return CFG_W'($urandom_range(0, MAX_BLOCKS - 1));
    endfunction

    // reserved count near the top of a large disk forces long scans
    function automatic logic [CFG_W-1:0] pick_reserved(input logic [CFG_W-1:0] total);
        int lim;
        int r;
        lim = (int'(total) > MAX_BLOCKS) ? MAX_BLOCKS : int'(total);
        r   = $urandom_range(0, 99);
        if (r < 40 || lim < 10)
            return CFG_W'($urandom_range(0, 3));
        else if (r < 65)
            return CFG_W'(lim - $urandom_range(1, 8));
        else if (r < 80)
            return CFG_W'($urandom_range(0, lim));
        else if (r < 88)
            return CFG_W'(lim + $urandom_range(0, 4));
        return CFG_W'($urandom_range(0, 4095));
    endfunction

    // ------------------------------------------------------------------
    // channel and register drivers
    // ------------------------------------------------------------------

    // register write, shadow copy updated at the same time
    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_TOTAL0: total_cfg[0] = value;
            CFG_TOTAL1: total_cfg[1] = value;
            CFG_RESV0:  resv_cfg[0]  = value;
            CFG_RESV1:  resv_cfg[1]  = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // one request; the expected response is queued once it is accepted
    task automatic send_request(input t_req_type req, input logic disk,
                                input logic [BLK_W-1:0] blk);
        int gap;
        gap = (no_idle || $urandom_range(0, 99) < 70) ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= req;
        req_ch.disk_select  <= disk;
        req_ch.block_number <= blk;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        pending_grants.push_back(grant_or_release(req, disk, blk));
    endtask

    // unit is idle once every response is back: one request in flight
    task automatic drain_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset counts: first-fit order, reuse, double free, below reserved
    task automatic test_reset_defaults();
        send_request(REQ_ALLOC, 1'b0, '0);
        send_request(REQ_ALLOC, 1'b1, '1);
        send_request(REQ_ALLOC, 1'b0, '0);
        send_request(REQ_FREE,  1'b0, 11'd1);
        send_request(REQ_FREE,  1'b0, 11'd1);
        send_request(REQ_FREE,  1'b0, 11'd0);
        send_request(REQ_FREE,  1'b0, 11'd2047);
        send_request(REQ_FREE,  1'b1, 11'd2047);
        send_request(REQ_ALLOC, 1'b0, '0);
        send_request(REQ_FREE,  1'b1, 11'd1);
        drain_results();
    endtask

    // empty disk, oversized count, zero reserved, reserved past the end,
    // and grants at the very top of a full-size disk
    task automatic test_config_extremes();
        cfg_write(CFG_TOTAL0, 12'd0);
        cfg_write(CFG_TOTAL1, 12'd4095);
        cfg_write(CFG_RESV0,  12'd0);
        cfg_write(CFG_RESV1,  12'd4095);
        send_request(REQ_ALLOC, 1'b0, '0);
        send_request(REQ_FREE,  1'b0, 11'd1);
        send_request(REQ_ALLOC, 1'b1, '0);
        send_request(REQ_FREE,  1'b1, 11'd2047);
        drain_results();

        cfg_write(CFG_TOTAL0, 12'd2048);
        cfg_write(CFG_RESV0,  12'd2046);
        cfg_write(CFG_TOTAL1, 12'd3);
        cfg_write(CFG_RESV1,  12'd0);
        send_request(REQ_ALLOC, 1'b0, '0);
        send_request(REQ_ALLOC, 1'b0, '0);
        send_request(REQ_ALLOC, 1'b0, '0);
        send_request(REQ_FREE,  1'b0, 11'd2047);
        send_request(REQ_FREE,  1'b0, 11'd2045);
        send_request(REQ_ALLOC, 1'b1, '0);
        send_request(REQ_ALLOC, 1'b1, '0);
        send_request(REQ_ALLOC, 1'b1, '0);
        send_request(REQ_FREE,  1'b1, 11'd3);
        drain_results();
    endtask

    // random phases: new counts each phase, then mixed traffic where most
    // frees target blocks that are actually held
    task automatic test_random_traffic();
        int alloc_pct;
        int r;
        int lim;
        logic disk;
        logic [BLK_W-1:0] blk;
        for (int phase = 0; phase < PHASES; phase++) begin
            cfg_write(CFG_TOTAL0, pick_total());
            cfg_write(CFG_TOTAL1, pick_total());
            cfg_write(CFG_RESV0,  pick_reserved(total_cfg[0]));
            cfg_write(CFG_RESV1,  pick_reserved(total_cfg[1]));
            no_idle   = (phase % 3 == 1);
            alloc_pct = $urandom_range(35, 75);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                disk = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) < alloc_pct) begin
                    // block number is don't-care here, keep it random
                    send_request(REQ_ALLOC, disk, BLK_W'($urandom));
                end else begin
                    r   = $urandom_range(0, 99);
                    lim = disk_limit(disk);
                    if (r < 65)
                        blk = pick_used_block(disk);
                    else if (r < 85)
                        blk = BLK_W'($urandom_range(0, (lim + 2 > MAX_BLOCKS - 1) ?
                                                       MAX_BLOCKS - 1 : lim + 2));
                    else
                        blk = BLK_W'($urandom);
                    send_request(REQ_FREE, disk, blk);
                end
            end
            drain_results();
        end
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // response side: random stalls on ready
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= pick_gap() - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // response checker: each response against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_grants.size() == 0) begin
                $error("response with no request waiting: block %0d status %0d",
                       rsp_ch.allocated_block, rsp_ch.status);
                fail_count++;
            end else begin
                want = pending_grants.pop_front();
                if (rsp_ch.allocated_block !== want.blk) begin
                    $error("allocated_block: expected %0d, got %0d",
                           want.blk, rsp_ch.allocated_block);
                    fail_count++;
                end
                if (rsp_ch.status !== want.st) begin
                    $error("status: expected %0d (%s), got %0d",
                           want.st, want.st.name(), rsp_ch.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long with no handshake on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL bitmap_block_allocator_unit");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_TOTAL0;
        i_cfg_data          = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_ALLOC;
        req_ch.disk_select  = 1'b0;
        req_ch.block_number = '0;
        rsp_ch.ready        = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_config_extremes();
        test_random_traffic();

        if (fail_count == 0)
            $display("PASS bitmap_block_allocator_unit");
        else
            $display("FAIL bitmap_block_allocator_unit");
        $finish;
    end

endmodule

/* files.f */
design/bba_pkg.sv
design/bba_ifs.sv
design/bba_bitmap_mem.sv
design/bba_word_find.sv
design/bitmap_block_allocator_unit.sv
verif/tb.sv
